### hdl/lkvc_pkg.sv
// Shared constants, state encoding and control structs for the LRU key-value cache.
package lkvc_pkg;

   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int CAP_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   // Register index is the word address bit above the byte offset.
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_COMMIT = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic is_get;
   } dp_stat_type;

endpackage

### hdl/lkvc_req_if.sv
// Request channel interface: operation, key and value with valid/ready.
interface lkvc_req_if import lkvc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

### hdl/lkvc_rsp_if.sv
// Response channel interface: hit flag and looked-up data with valid/ready.
interface lkvc_rsp_if import lkvc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [VALUE_W-1:0] data_out;

   modport source (output valid, output hit, output data_out, input ready);
   modport sink   (input valid, input hit, input data_out, output ready);
endinterface

### hdl/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: channels, capacity register, controller and datapath.
// Fully associative key/value store with least-recently-used replacement. A get request
// (mode 0) returns hit and the stored value (zero on a miss) and makes the entry most
// recent; a put request (mode 1) updates or inserts an entry and returns nothing. Each
// request is accepted, then its key is compared against SLOTS = min(MAX_ENTRIES, 31) slots
// read one entry per cycle through the single read port of the entry RAM, and then
// committed; a get also waits at commit while the previous response has not
// been taken. The capacity register (byte address 0, reset 16) sets how many entries
// are kept; zero acts as one and values above SLOTS act as SLOTS. Lowering it keeps the
// contents until the next insert of a new key, which drops the oldest surplus entries.
module lru_key_value_cache_unit import lkvc_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lkvc_req_if.sink              req,
   lkvc_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CAP_MAX = (1 << CAP_W) - 1;
   localparam int SLOTS   = (MAX_ENTRIES < CAP_MAX) ? MAX_ENTRIES : CAP_MAX;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CAP_W-1:0] cap_m1;
   logic             csr_write;
   dp_cmd_type       cmd;
   dp_stat_type      stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_W-1] == CSR_IDX_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_IDX_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;

   // effective capacity minus one; the effective capacity is clamped to one..SLOTS
   always_comb begin
      if (capacity_ff == '0) begin
         cap_m1 = '0;
      end else if (capacity_ff > CAP_W'(SLOTS)) begin
         cap_m1 = CAP_W'(SLOTS - 1);
      end else begin
         cap_m1 = capacity_ff - 1'b1;
      end
   end

   lkvc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   lkvc_dp #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_mode    (req.mode),
      .req_key     (req.key),
      .req_value   (req.value),
      .cap_m1      (cap_m1),
      .rsp_hit     (rsp.hit),
      .rsp_data_out(rsp.data_out)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted but block still ready");

   a_get_response: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && stat.is_get) |=> rsp.valid)
      else $error("get committed without a pending response");

   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req.ready)
      else $error("block not ready after commit");
`endif

endmodule

### hdl/lkvc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module lkvc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lkvc_ctrl.sv
// Controller state machine: accept, search sweep, commit and response valid.
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // hold a get until the response register is free
            if (!stat.is_get || out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit && stat.is_get) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/lkvc_dp.sv
// Datapath: entry RAM, key search sweep, recency ranks, occupancy and response data.
module lkvc_dp import lkvc_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic               req_mode,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [CAP_W-1:0]   cap_m1,
   output logic               rsp_hit,
   output logic [VALUE_W-1:0] rsp_data_out
);

   // capacity never exceeds what the register can hold, so no slot past that is used
   localparam int CAP_MAX = (1 << CAP_W) - 1;
   localparam int SLOTS   = (MAX_ENTRIES < CAP_MAX) ? MAX_ENTRIES : CAP_MAX;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int RANK_W  = IDX_W;
   localparam int ENTRY_W = KEY_W + VALUE_W;

   logic               mode_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [CNT_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_slot_ff;
   logic [VALUE_W-1:0] hit_value_ff;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_slot_ff;

   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [RANK_W-1:0]  rank_ff [SLOTS];
   logic [RANK_W-1:0]  rank_in [SLOTS];
   logic [CNT_W-1:0]   occ_ff, occ_in;

   logic               hit_out_ff;
   logic [VALUE_W-1:0] data_out_ff;

   logic               issue;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic [VALUE_W-1:0] rd_value;
   logic               cur_valid;
   logic [RANK_W-1:0]  cur_rank;
   logic               key_match;
   logic               free_here;
   logic [RANK_W-1:0]  hit_rank;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   lkvc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS),
      .ADDR_W(IDX_W)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // one entry read per cycle; compare in the cycle after the address
   assign issue    = cmd.scan && (scan_cnt_ff < CNT_W'(SLOTS));
   assign rd_addr  = scan_cnt_ff[IDX_W-1:0];
   assign rd_key   = rd_data[ENTRY_W-1:VALUE_W];
   assign rd_value = rd_data[VALUE_W-1:0];

   assign cur_valid = valid_ff[cmp_idx_ff];
   assign cur_rank  = rank_ff[cmp_idx_ff];
   assign key_match = cmp_vld_ff && cur_valid && (rd_key == key_ff);
   // lowest slot that is free once entries beyond capacity are dropped
   assign free_here = cmp_vld_ff && !free_found_ff
                      && (!cur_valid || (CAP_W'(cur_rank) >= cap_m1));

   assign stat.scan_done = cmp_vld_ff && (cmp_idx_ff == IDX_W'(SLOTS - 1));
   assign stat.is_get    = (mode_ff == MODE_GET);

   always_comb begin
      scan_cnt_in   = scan_cnt_ff;
      cmp_vld_in    = issue;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      if (cmd.load) begin
         scan_cnt_in   = '0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else begin
         if (issue) begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
         end
         if (key_match) begin
            hit_in = 1'b1;
         end
         if (free_here) begin
            free_found_in = 1'b1;
         end
      end
   end

   assign hit_rank = rank_ff[hit_slot_ff];

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      occ_in   = occ_ff;
      wr_en    = 1'b0;
      wr_addr  = hit_slot_ff;
      wr_data  = {key_ff, value_ff};
      if (cmd.commit) begin
         if (hit_ff) begin
            // age everything newer than the touched entry
            for (int i = 0; i < SLOTS; i++) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[hit_slot_ff] = '0;
            if (mode_ff == MODE_PUT) begin
               wr_en = 1'b1;
            end
         end else if (mode_ff == MODE_PUT) begin
            // drop the oldest entries past capacity, age the rest
            for (int i = 0; i < SLOTS; i++) begin
               if (valid_ff[i]) begin
                  if (CAP_W'(rank_ff[i]) >= cap_m1) begin
                     valid_in[i] = 1'b0;
                  end else begin
                     rank_in[i] = rank_ff[i] + 1'b1;
                  end
               end
            end
            valid_in[free_slot_ff] = 1'b1;
            rank_in[free_slot_ff]  = '0;
            wr_en   = 1'b1;
            wr_addr = free_slot_ff;
            if (CAP_W'(occ_ff) > cap_m1) begin
               occ_in = CNT_W'(cap_m1) + 1'b1;
            end else begin
               occ_in = occ_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
         occ_ff        <= '0;
      end else begin
         scan_cnt_ff   <= scan_cnt_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff    <= rank_in;
      cmp_idx_ff <= rd_addr;
      if (cmd.load) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (key_match) begin
         hit_slot_ff  <= cmp_idx_ff;
         hit_value_ff <= rd_value;
      end
      if (free_here) begin
         free_slot_ff <= cmp_idx_ff;
      end
      if (cmd.commit && (mode_ff == MODE_GET)) begin
         hit_out_ff  <= hit_ff;
         data_out_ff <= hit_ff ? hit_value_ff : '0;
      end
   end

   assign rsp_hit      = hit_out_ff;
   assign rsp_data_out = data_out_ff;

endmodule
